// ===== rtl/core/dwf_pkg.sv =====
// ----------------------------------------------------------------------------
// Dipole wrench package
// Shared widths, constants and the item type passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package dwf_pkg;

  // Field and result widths.
  localparam int IN_W     = 24;
  localparam int IN_COUNT = 11;
  localparam int OUT_W    = 48;
  localparam int OUT_COUNT = 6;
  localparam int S_DATA_W = IN_W * IN_COUNT;
  localparam int M_DATA_W = OUT_W * OUT_COUNT;

  // Configuration port.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Register indexes on paddr[3:2].
  typedef enum logic [1:0] {
    REG_MOMENT_X = 2'd0,
    REG_MOMENT_Y = 2'd1,
    REG_MOMENT_Z = 2'd2
  } reg_index_t;

  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // One classified item: the input fields plus the derived gzz term.
  typedef struct packed {
    logic signed [IN_W-1:0] pos_x;
    logic signed [IN_W-1:0] pos_y;
    logic signed [IN_W-1:0] pos_z;
    logic signed [IN_W-1:0] field_x;
    logic signed [IN_W-1:0] field_y;
    logic signed [IN_W-1:0] field_z;
    logic signed [IN_W-1:0] grad_xx;
    logic signed [IN_W-1:0] grad_xy;
    logic signed [IN_W-1:0] grad_xz;
    logic signed [IN_W-1:0] grad_yy;
    logic signed [IN_W-1:0] grad_yz;
    logic signed [IN_W:0]   grad_sum;   // gxx + gyy, the negated gzz
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/core/dipole_wrench_from_field.sv =====
// ----------------------------------------------------------------------------
// Dipole wrench from field
// Force and torque about the origin on a magnetic point dipole.
// ----------------------------------------------------------------------------
// The block takes one item per clock while its queue has room and gives one
// result per item, in order. The dipole moment is set through the APB
// registers (moment_x at 0x0, moment_y at 0x4, moment_z at 0x8, 24-bit
// signed) and should be written while no item is in flight. An item goes
// from s_tdata into a queue of FIFO_DEPTH entries and then through a
// six-stage multiply and add pipeline whose last stage is the output
// register. The pipeline holds as a whole while a result waits with m_tready
// low, and the queue keeps s_tready high until it fills. Force is exact at
// 2^-32 N, torque is rounded half up to 2^-36 N.m, both clamped to 48 bits
// with m_tuser flagging any clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module dipole_wrench_from_field #(
  parameter int FIFO_DEPTH = dwf_pkg::QUEUE_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Configuration port.
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [dwf_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [dwf_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [dwf_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready,
  // Input items.
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // pos_x, pos_y, pos_z, field_x, field_y, field_z, grad_xx, grad_xy,
  // grad_xz, grad_yy, grad_yz; 24 bits each from bit 0 up
  input  wire logic [dwf_pkg::S_DATA_W-1:0]      s_tdata,
  // Result items.
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // force_x, force_y, force_z, torque_x, torque_y, torque_z; 48 bits each
  // from bit 0 up
  output logic [dwf_pkg::M_DATA_W-1:0]           m_tdata,
  // saturated
  output logic                                   m_tuser
);
  import dwf_pkg::*;

  logic signed [IN_W-1:0] moment_x;
  logic signed [IN_W-1:0] moment_y;
  logic signed [IN_W-1:0] moment_z;
  logic                   cfg_write;
  reg_index_t             cfg_index;
  logic                   queue_full;
  logic                   push;
  item_t                  push_item;
  logic                   pop;
  logic                   head_valid;
  item_t                  head_item;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_t'(paddr[3:2]);

  // Moment registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      moment_x <= '0;
      moment_y <= '0;
      moment_z <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MOMENT_X: moment_x <= $signed(pwdata[IN_W-1:0]);
        REG_MOMENT_Y: moment_y <= $signed(pwdata[IN_W-1:0]);
        REG_MOMENT_Z: moment_z <= $signed(pwdata[IN_W-1:0]);
        default: ;
      endcase
    end
  end

  // Register read back, sign extended.
  always_comb begin
    case (cfg_index)
      REG_MOMENT_X: prdata = APB_DATA_W'(moment_x);
      REG_MOMENT_Y: prdata = APB_DATA_W'(moment_y);
      REG_MOMENT_Z: prdata = APB_DATA_W'(moment_z);
      default:      prdata = '0;
    endcase
  end

  dwf_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  dwf_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (head_valid),
    .head_item (head_item)
  );

  dwf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .moment_x   (moment_x),
    .moment_y   (moment_y),
    .moment_z   (moment_z),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

`default_nettype wire

// ===== rtl/core/dwf_queue.sv =====
// ----------------------------------------------------------------------------
// Dipole wrench item queue
// Small register-file queue that decouples the front from the back pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module dwf_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire dwf_pkg::item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output dwf_pkg::item_t      head_item
);
  import dwf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  item_t            entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign head_item = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dwf_front.sv =====
// ----------------------------------------------------------------------------
// Dipole wrench front end
// Accepts input items, unpacks the fields and forms the gxx + gyy term.
// ----------------------------------------------------------------------------
`default_nettype none

module dwf_front (
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [dwf_pkg::S_DATA_W-1:0]  s_tdata,
  input  wire logic                          queue_full,
  output logic                               push,
  output dwf_pkg::item_t                     push_item
);
  import dwf_pkg::*;

  // An item is taken whenever the queue has room.
  assign s_tready = !queue_full;
  assign push     = s_tvalid && !queue_full;

  // Unpack fields, lowest field in the lowest bits.
  always_comb begin
    push_item.pos_x    = $signed(s_tdata[0*IN_W +: IN_W]);
    push_item.pos_y    = $signed(s_tdata[1*IN_W +: IN_W]);
    push_item.pos_z    = $signed(s_tdata[2*IN_W +: IN_W]);
    push_item.field_x  = $signed(s_tdata[3*IN_W +: IN_W]);
    push_item.field_y  = $signed(s_tdata[4*IN_W +: IN_W]);
    push_item.field_z  = $signed(s_tdata[5*IN_W +: IN_W]);
    push_item.grad_xx  = $signed(s_tdata[6*IN_W +: IN_W]);
    push_item.grad_xy  = $signed(s_tdata[7*IN_W +: IN_W]);
    push_item.grad_xz  = $signed(s_tdata[8*IN_W +: IN_W]);
    push_item.grad_yy  = $signed(s_tdata[9*IN_W +: IN_W]);
    push_item.grad_yz  = $signed(s_tdata[10*IN_W +: IN_W]);
    // The trace-free gradient gives gzz = -(gxx + gyy).
    push_item.grad_sum = (IN_W+1)'($signed(s_tdata[6*IN_W +: IN_W]))
                       + (IN_W+1)'($signed(s_tdata[9*IN_W +: IN_W]));
  end

endmodule

`default_nettype wire

// ===== rtl/core/dwf_back.sv =====
// ----------------------------------------------------------------------------
// Dipole wrench back end
// Six-stage pipeline computing force and torque, with saturation and an
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dwf_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic signed [dwf_pkg::IN_W-1:0] moment_x,
  input  wire logic signed [dwf_pkg::IN_W-1:0] moment_y,
  input  wire logic signed [dwf_pkg::IN_W-1:0] moment_z,
  input  wire logic                          head_valid,
  input  wire dwf_pkg::item_t                head_item,
  output logic                               pop,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [dwf_pkg::M_DATA_W-1:0]       m_tdata,
  output logic                               m_tuser
);
  import dwf_pkg::*;

  localparam int PROD_W  = 2 * IN_W;          // moment times 24-bit field
  localparam int FORCE_W = PROD_W + 2;        // exact force
  localparam int SPLIT_W = FORCE_W / 2;       // low part of the force split
  localparam int HI_W    = FORCE_W - SPLIT_W;
  localparam int PH_W    = IN_W + HI_W;       // r times high part
  localparam int PL_W    = IN_W + SPLIT_W + 1;// r times low part
  localparam int ACC_W   = IN_W + FORCE_W + 2;// exact torque sum at 2^-52
  localparam int SHIFT   = 16;                // 2^-52 down to 2^-36
  localparam int SAT_W   = ACC_W - SHIFT;
  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'((65'sd1 <<< (OUT_W-1)) - 65'sd1);
  localparam logic signed [SAT_W-1:0] SAT_MIN = -SAT_W'(65'sd1 <<< (OUT_W-1));
  localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(65'sd1 <<< (SHIFT-1));

  // Clamp to the output range; the top bit of the result is the clip flag.
  function automatic logic [OUT_W:0] sat_out(input logic signed [SAT_W-1:0] v);
    logic [OUT_W:0] r;
    if (v > SAT_MAX) begin
      r = {1'b1, SAT_MAX[OUT_W-1:0]};
    end else if (v < SAT_MIN) begin
      r = {1'b1, SAT_MIN[OUT_W-1:0]};
    end else begin
      r = {1'b0, v[OUT_W-1:0]};
    end
    return r;
  endfunction

  logic en;
  logic v1, v2, v3, v4, v5;

  // Stage 1: all moment products.
  logic signed [PROD_W-1:0]   s1_fxx, s1_fxy, s1_fxz;
  logic signed [PROD_W-1:0]   s1_fyx, s1_fyy, s1_fyz;
  logic signed [PROD_W-1:0]   s1_fzx, s1_fzy;
  logic signed [PROD_W:0]     s1_fzz;
  logic signed [PROD_W-1:0]   s1_bx1, s1_bx2, s1_by1, s1_by2, s1_bz1, s1_bz2;
  logic signed [IN_W-1:0]     s1_rx, s1_ry, s1_rz;

  // Stage 2: exact force and m x b.
  logic signed [FORCE_W-1:0]  s2_fx, s2_fy, s2_fz;
  logic signed [PROD_W:0]     s2_mbx, s2_mby, s2_mbz;
  logic signed [IN_W-1:0]     s2_rx, s2_ry, s2_rz;

  // Stage 3: split partial products of r x f.
  logic signed [PH_W-1:0]     s3_h [6];
  logic signed [PL_W-1:0]     s3_l [6];
  logic signed [FORCE_W-1:0]  s3_fx, s3_fy, s3_fz;
  logic signed [PROD_W:0]     s3_mbx, s3_mby, s3_mbz;

  // Stage 4: full products.
  logic signed [ACC_W-1:0]    s4_p [6];
  logic signed [FORCE_W-1:0]  s4_fx, s4_fy, s4_fz;
  logic signed [PROD_W:0]     s4_mbx, s4_mby, s4_mbz;

  // Stage 5: rounded torque.
  logic signed [SAT_W-1:0]    s5_tx, s5_ty, s5_tz;
  logic signed [FORCE_W-1:0]  s5_fx, s5_fy, s5_fz;

  // Stage 6: saturated results.
  logic [OUT_W:0]             sat_res [6];

  // Operand pairs for r x f: (r, f) in the order ry fz, rz fy, rz fx, rx fz,
  // rx fy, ry fx.
  logic signed [IN_W-1:0]     mul_r [6];
  logic signed [FORCE_W-1:0]  mul_f [6];

  logic signed [ACC_W-1:0]    acc_x, acc_y, acc_z;

  // The whole pipeline moves unless a result waits at the output.
  assign en  = !m_tvalid || m_tready;
  assign pop = head_valid && en;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v1 <= head_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      m_tvalid <= v5;
    end
  end

  // Stage 1 multipliers.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_fxx <= moment_x * head_item.grad_xx;
      s1_fxy <= moment_y * head_item.grad_xy;
      s1_fxz <= moment_z * head_item.grad_xz;
      s1_fyx <= moment_x * head_item.grad_xy;
      s1_fyy <= moment_y * head_item.grad_yy;
      s1_fyz <= moment_z * head_item.grad_yz;
      s1_fzx <= moment_x * head_item.grad_xz;
      s1_fzy <= moment_y * head_item.grad_yz;
      s1_fzz <= moment_z * head_item.grad_sum;
      s1_bx1 <= moment_y * head_item.field_z;
      s1_bx2 <= moment_z * head_item.field_y;
      s1_by1 <= moment_z * head_item.field_x;
      s1_by2 <= moment_x * head_item.field_z;
      s1_bz1 <= moment_x * head_item.field_y;
      s1_bz2 <= moment_y * head_item.field_x;
      s1_rx  <= head_item.pos_x;
      s1_ry  <= head_item.pos_y;
      s1_rz  <= head_item.pos_z;
    end
  end

  // Stage 2 sums.
  always_ff @(posedge clk) begin
    if (en) begin
      s2_fx  <= FORCE_W'(s1_fxx) + FORCE_W'(s1_fxy) + FORCE_W'(s1_fxz);
      s2_fy  <= FORCE_W'(s1_fyx) + FORCE_W'(s1_fyy) + FORCE_W'(s1_fyz);
      s2_fz  <= FORCE_W'(s1_fzx) + FORCE_W'(s1_fzy) - FORCE_W'(s1_fzz);
      s2_mbx <= (PROD_W+1)'(s1_bx1) - (PROD_W+1)'(s1_bx2);
      s2_mby <= (PROD_W+1)'(s1_by1) - (PROD_W+1)'(s1_by2);
      s2_mbz <= (PROD_W+1)'(s1_bz1) - (PROD_W+1)'(s1_bz2);
      s2_rx  <= s1_rx;
      s2_ry  <= s1_ry;
      s2_rz  <= s1_rz;
    end
  end

  // Operand selection for the cross product with the position.
  always_comb begin
    mul_r[0] = s2_ry;  mul_f[0] = s2_fz;
    mul_r[1] = s2_rz;  mul_f[1] = s2_fy;
    mul_r[2] = s2_rz;  mul_f[2] = s2_fx;
    mul_r[3] = s2_rx;  mul_f[3] = s2_fz;
    mul_r[4] = s2_rx;  mul_f[4] = s2_fy;
    mul_r[5] = s2_ry;  mul_f[5] = s2_fx;
  end

  // Stage 3: each wide product is split into a signed high and an unsigned
  // low half of the force.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        s3_h[i] <= mul_r[i] * $signed(mul_f[i][FORCE_W-1:SPLIT_W]);
        s3_l[i] <= mul_r[i] * $signed({1'b0, mul_f[i][SPLIT_W-1:0]});
      end
      s3_fx  <= s2_fx;
      s3_fy  <= s2_fy;
      s3_fz  <= s2_fz;
      s3_mbx <= s2_mbx;
      s3_mby <= s2_mby;
      s3_mbz <= s2_mbz;
    end
  end

  // Stage 4: recombine the halves.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        s4_p[i] <= (ACC_W'(s3_h[i]) <<< SPLIT_W) + ACC_W'(s3_l[i]);
      end
      s4_fx  <= s3_fx;
      s4_fy  <= s3_fy;
      s4_fz  <= s3_fz;
      s4_mbx <= s3_mbx;
      s4_mby <= s3_mby;
      s4_mbz <= s3_mbz;
    end
  end

  // Torque sums at 2^-52 with the rounding half added.
  always_comb begin
    acc_x = s4_p[0] - s4_p[1] + (ACC_W'(s4_mbx) <<< SHIFT) + HALF;
    acc_y = s4_p[2] - s4_p[3] + (ACC_W'(s4_mby) <<< SHIFT) + HALF;
    acc_z = s4_p[4] - s4_p[5] + (ACC_W'(s4_mbz) <<< SHIFT) + HALF;
  end

  // Stage 5: truncate the half-added sum to 2^-36.
  always_ff @(posedge clk) begin
    if (en) begin
      s5_tx <= $signed(acc_x[ACC_W-1:SHIFT]);
      s5_ty <= $signed(acc_y[ACC_W-1:SHIFT]);
      s5_tz <= $signed(acc_z[ACC_W-1:SHIFT]);
      s5_fx <= s4_fx;
      s5_fy <= s4_fy;
      s5_fz <= s4_fz;
    end
  end

  // Saturation of all six components.
  always_comb begin
    sat_res[0] = sat_out(SAT_W'(s5_fx));
    sat_res[1] = sat_out(SAT_W'(s5_fy));
    sat_res[2] = sat_out(SAT_W'(s5_fz));
    sat_res[3] = sat_out(s5_tx);
    sat_res[4] = sat_out(s5_ty);
    sat_res[5] = sat_out(s5_tz);
  end

  // Stage 6: output register.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < OUT_COUNT; i++) begin
        m_tdata[i*OUT_W +: OUT_W] <= sat_res[i][OUT_W-1:0];
      end
      m_tuser <= sat_res[0][OUT_W] | sat_res[1][OUT_W] | sat_res[2][OUT_W]
               | sat_res[3][OUT_W] | sat_res[4][OUT_W] | sat_res[5][OUT_W];
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_dipole_wrench_from_field.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dipole wrench testbench
// Streams field samples through the block under several dipole moments and
// compares every force, torque and clip flag against a bit-exact predictor.
// ----------------------------------------------------------------------------

module tb_dipole_wrench_from_field;
  import dwf_pkg::*;

  localparam int STALL_LIMIT     = 5000;
  localparam int SETTLE_CYCLES   = 12;
  localparam int LONG_HOLD       = 80;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int MAX_REPORTS     = 10;
  localparam int IDLE_PERCENT    = 30;

  // Address slot with no register behind it.
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  localparam logic signed [IN_W-1:0] FIELD_MAX = 24'sh7F_FFFF;
  localparam logic signed [IN_W-1:0] FIELD_MIN = 24'sh80_0000;
  localparam logic signed [127:0] SAT_HI     = (128'sd1 <<< (OUT_W - 1)) - 128'sd1;
  localparam logic signed [127:0] SAT_LO     = -(128'sd1 <<< (OUT_W - 1));
  localparam logic signed [127:0] ROUND_HALF = 128'sd32768;

  // Input item, first field in the lowest bits as on s_tdata.
  typedef struct packed {
    logic signed [IN_W-1:0] grad_yz;
    logic signed [IN_W-1:0] grad_yy;
    logic signed [IN_W-1:0] grad_xz;
    logic signed [IN_W-1:0] grad_xy;
    logic signed [IN_W-1:0] grad_xx;
    logic signed [IN_W-1:0] field_z;
    logic signed [IN_W-1:0] field_y;
    logic signed [IN_W-1:0] field_x;
    logic signed [IN_W-1:0] pos_z;
    logic signed [IN_W-1:0] pos_y;
    logic signed [IN_W-1:0] pos_x;
  } sample_t;

  // Result item, laid out as on m_tdata.
  typedef struct packed {
    logic [OUT_W-1:0] torque_z;
    logic [OUT_W-1:0] torque_y;
    logic [OUT_W-1:0] torque_x;
    logic [OUT_W-1:0] force_z;
    logic [OUT_W-1:0] force_y;
    logic [OUT_W-1:0] force_x;
  } wrench_data_t;

  typedef struct {
    wrench_data_t data;
    logic         saturated;
  } wrench_t;

  string wrench_field_name [0:OUT_COUNT-1] =
    '{"force_x", "force_y", "force_z", "torque_x", "torque_y", "torque_z"};

  logic                  clk     = 1'b0;
  logic                  rst     = 1'b1;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // pos_x, pos_y, pos_z, field_x, field_y, field_z, grad_xx, grad_xy,
  // grad_xz, grad_yy, grad_yz; 24 bits each from bit 0 up
  logic [S_DATA_W-1:0]   s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // force_x, force_y, force_z, torque_x, torque_y, torque_z; 48 bits each
  // from bit 0 up
  logic [M_DATA_W-1:0]   m_tdata;
  // saturated
  logic                  m_tuser;

  // Testbench copy of the moment registers.
  logic signed [IN_W-1:0] moment_x = '0;
  logic signed [IN_W-1:0] moment_y = '0;
  logic signed [IN_W-1:0] moment_z = '0;

  sample_t pending_sample_q [$];
  wrench_t expected_wrench_q [$];
  wrench_t oldest_wrench;

  logic idle_on      = 1'b1;
  logic hold_request = 1'b0;
  logic offer_live   = 1'b0;
  int   hold_left    = 0;
  int   quiet_cycles = 0;
  int   mismatch_count = 0;

  dipole_wrench_from_field dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Clamp to the 48-bit result range and tell whether clipping happened.
  function automatic logic [OUT_W-1:0] clamp48(input logic signed [127:0] v,
                                               output logic clipped);
    clipped = 1'b0;
    if (v > SAT_HI) begin
      v = SAT_HI;
      clipped = 1'b1;
    end else if (v < SAT_LO) begin
      v = SAT_LO;
      clipped = 1'b1;
    end
    return v[OUT_W-1:0];
  endfunction

  // Force is exact at 2^-32 N. Torque sums m x b (shifted up by 16) and
  // r x f at 2^-52 N.m, then rounds half up to 2^-36 N.m.
  function automatic wrench_t compute_wrench(sample_t s);
    logic signed [127:0] mx, my, mz, rx, ry, rz, bx, by, bz;
    logic signed [127:0] gxx, gxy, gxz, gyy, gyz;
    logic signed [127:0] fx, fy, fz, tx, ty, tz;
    logic    clipped;
    wrench_t w;
    mx = moment_x;  my = moment_y;  mz = moment_z;
    rx = s.pos_x;   ry = s.pos_y;   rz = s.pos_z;
    bx = s.field_x; by = s.field_y; bz = s.field_z;
    gxx = s.grad_xx; gxy = s.grad_xy; gxz = s.grad_xz;
    gyy = s.grad_yy; gyz = s.grad_yz;
    fx = mx * gxx + my * gxy + mz * gxz;
    fy = mx * gxy + my * gyy + mz * gyz;
    fz = mx * gxz + my * gyz - mz * (gxx + gyy);
    tx = (((my * bz - mz * by) <<< 16) + ry * fz - rz * fy + ROUND_HALF) >>> 16;
    ty = (((mz * bx - mx * bz) <<< 16) + rz * fx - rx * fz + ROUND_HALF) >>> 16;
    tz = (((mx * by - my * bx) <<< 16) + rx * fy - ry * fx + ROUND_HALF) >>> 16;
    w.saturated = 1'b0;
    w.data.force_x  = clamp48(fx, clipped); w.saturated |= clipped;
    w.data.force_y  = clamp48(fy, clipped); w.saturated |= clipped;
    w.data.force_z  = clamp48(fz, clipped); w.saturated |= clipped;
    w.data.torque_x = clamp48(tx, clipped); w.saturated |= clipped;
    w.data.torque_y = clamp48(ty, clipped); w.saturated |= clipped;
    w.data.torque_z = clamp48(tz, clipped); w.saturated |= clipped;
    return w;
  endfunction

  // Random value whose magnitude spans the given number of bits.
  function automatic logic signed [IN_W-1:0] rand_width_value(int bits);
    logic signed [IN_W-1:0] v;
    v = IN_W'($urandom);
    v = v <<< (IN_W - bits);
    v = v >>> (IN_W - bits);
    return v;
  endfunction

  function automatic logic signed [IN_W-1:0] pick_extreme();
    case ($urandom_range(4))
      0:       return FIELD_MAX;
      1:       return FIELD_MIN;
      2:       return '0;
      3:       return 24'sd1;
      default: return -24'sd1;
    endcase
  endfunction

  // Moment styles: full range, any magnitude, extremes, small magnitude.
  function automatic logic signed [IN_W-1:0] pick_moment(int style);
    case (style)
      0:       return IN_W'($urandom);
      1:       return rand_width_value($urandom_range(1, IN_W));
      2:       return pick_extreme();
      default: return rand_width_value($urandom_range(1, 12));
    endcase
  endfunction

  function automatic sample_t uniform_sample(logic signed [IN_W-1:0] v);
    logic [S_DATA_W-1:0] bits;
    for (int i = 0; i < IN_COUNT; i++) bits[i*IN_W +: IN_W] = v;
    return bits;
  endfunction

  // Mostly fields of random magnitude, so that results stay unclipped
  // often, with full-range and extreme items mixed in.
  function automatic sample_t random_sample();
    logic [S_DATA_W-1:0] bits;
    int style;
    style = $urandom_range(99);
    for (int i = 0; i < IN_COUNT; i++) begin
      if (style < 15) begin
        bits[i*IN_W +: IN_W] = IN_W'($urandom);
      end else if (style < 22) begin
        bits[i*IN_W +: IN_W] = pick_extreme();
      end else begin
        bits[i*IN_W +: IN_W] = rand_width_value($urandom_range(1, IN_W));
      end
    end
    return bits;
  endfunction

  // Register write: setup cycle, then access cycle. Bits above 24 carry junk.
  task automatic write_reg(logic [1:0] idx, logic signed [IN_W-1:0] value);
    logic [7:0] junk;
    junk = 8'($urandom);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_MOMENT_X: moment_x = value;
      REG_MOMENT_Y: moment_y = value;
      REG_MOMENT_Z: moment_z = value;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_moments(logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] y,
                               logic signed [IN_W-1:0] z);
    write_reg(REG_MOMENT_X, x);
    write_reg(REG_MOMENT_Y, y);
    write_reg(REG_MOMENT_Z, z);
  endtask

  task automatic wait_idle();
    while (pending_sample_q.size() != 0 || offer_live || expected_wrench_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Extreme field values against the current moment.
  task automatic queue_extreme_set();
    sample_t s;
    pending_sample_q.push_back(uniform_sample('0));
    pending_sample_q.push_back(uniform_sample(FIELD_MAX));
    pending_sample_q.push_back(uniform_sample(FIELD_MIN));
    // Field only: the m x b term alone.
    s = uniform_sample('0);
    s.field_x = FIELD_MAX; s.field_y = FIELD_MIN; s.field_z = FIELD_MAX;
    pending_sample_q.push_back(s);
    // Gradients only, with gxx + gyy beyond the 24-bit range.
    s = uniform_sample('0);
    s.grad_xx = FIELD_MIN; s.grad_yy = FIELD_MIN;
    s.grad_xy = FIELD_MAX; s.grad_xz = FIELD_MIN; s.grad_yz = FIELD_MAX;
    pending_sample_q.push_back(s);
    s = uniform_sample(FIELD_MAX);
    s.field_y = FIELD_MIN; s.pos_z = FIELD_MIN;
    s.grad_yy = FIELD_MIN; s.grad_xz = FIELD_MIN;
    pending_sample_q.push_back(s);
  endtask

  // Accepted input items turn into expected results here.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      expected_wrench_q.push_back(compute_wrench(pending_sample_q.pop_front()));
      offer_live = 1'b0;
    end
  end

  // Sender: keeps an offered item steady until it is taken.
  always @(negedge clk) begin
    if (!offer_live) begin
      if (pending_sample_q.size() != 0 &&
          !(idle_on && $urandom_range(99) < IDLE_PERCENT)) begin
        s_tdata  <= pending_sample_q[0];
        s_tvalid <= 1'b1;
        offer_live = 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus long holds on request.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LONG_HOLD;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
    end
  end

  task automatic report_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%s mismatch at %0t: expected %0d, got %0d",
               name, $realtime, $signed(want), $signed(got));
  endtask

  // Compare each result item with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_wrench_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("result item with nothing expected at %0t: tdata=%h tuser=%b",
                   $realtime, m_tdata, m_tuser);
      end else begin
        oldest_wrench = expected_wrench_q.pop_front();
        for (int k = 0; k < OUT_COUNT; k++) begin
          if (m_tdata[k*OUT_W +: OUT_W] !== oldest_wrench.data[k*OUT_W +: OUT_W])
            report_field(wrench_field_name[k], oldest_wrench.data[k*OUT_W +: OUT_W],
                         m_tdata[k*OUT_W +: OUT_W]);
        end
        if (m_tuser !== oldest_wrench.saturated)
          report_field("saturated", {{(OUT_W-1){1'b0}}, oldest_wrench.saturated},
                       {{(OUT_W-1){1'b0}}, m_tuser});
      end
    end
  end

  // Watchdog: too long without any item moving on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sample_t s;
    int style;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Moments still at reset: every result must be zero.
    pending_sample_q.push_back(uniform_sample(FIELD_MAX));
    pending_sample_q.push_back(uniform_sample(FIELD_MIN));
    wait_idle();

    // Largest moment; the write to the empty slot must change nothing.
    write_moments(FIELD_MAX, FIELD_MAX, FIELD_MAX);
    write_reg(REG_UNMAPPED, FIELD_MIN);
    queue_extreme_set();
    wait_idle();

    write_moments(FIELD_MIN, FIELD_MIN, FIELD_MIN);
    queue_extreme_set();
    wait_idle();

    // Unit moment along x: torque_z is gxy scaled down by 2^16, at the rounding boundary.
    write_moments(24'sd1, '0, '0);
    s = uniform_sample('0);
    s.pos_x = 24'sd1;
    s.grad_xy = 24'sd32768;  pending_sample_q.push_back(s);
    s.grad_xy = -24'sd32768; pending_sample_q.push_back(s);
    s.grad_xy = -24'sd32769; pending_sample_q.push_back(s);
    s.grad_xy = 24'sd32767;  pending_sample_q.push_back(s);
    wait_idle();

    // Random phases, each under a fresh moment.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      style = p % 4;
      write_moments(pick_moment(style), pick_moment(style), pick_moment(style));
      if (p % 3 == 1) write_reg(REG_UNMAPPED, pick_moment(0));
      idle_on = (p != 2);
      if (p == 4 || p == 7) hold_request = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) pending_sample_q.push_back(random_sample());
      wait_idle();
    end

    if (mismatch_count == 0 && expected_wrench_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
